// ===== rtl/bsc_pkg.sv =====
// Shared constants and helpers for the barometric sensor compensation block.
`default_nettype none

package bsc_pkg;

    // Datapath word width (C uint32_t arithmetic)
    localparam int unsigned W = 32;

    // Configuration register indexes
    localparam logic [1:0] CFG_TEMP    = 2'd0;
    localparam logic [1:0] CFG_PRESS_A = 2'd1;
    localparam logic [1:0] CFG_PRESS_B = 2'd2;
    localparam logic [1:0] CFG_PRESS_C = 2'd3;

    // Compensation constants
    localparam logic [W-1:0] K_X1_OFFSET = 32'd64000;
    localparam logic [W-1:0] K_ADC_FULL  = 32'd1048576;
    localparam logic [W-1:0] K_PSCALE    = 32'd3125;
    localparam logic [W-1:0] K_HALF_ONE  = 32'd32768;
    localparam logic [W-1:0] K_ROUND     = 32'd128;

    // Sign-extend a 16-bit calibration halfword
    function automatic logic [W-1:0] sx16(input logic [15:0] h);
        return {{(W-16){h[15]}}, h};
    endfunction

    // Arithmetic right shift of a 32-bit word
    function automatic logic [W-1:0] asr(input logic [W-1:0] v, input logic [4:0] s);
        return $unsigned($signed(v) >>> s);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bsc_mul.sv =====
// Bit-serial 32x32 multiplier, low 32 bits of the product, one bit per cycle.
`default_nettype none

module bsc_mul (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [bsc_pkg::W-1:0] i_a,
    input  wire logic [bsc_pkg::W-1:0] i_b,
    output logic                      o_done,
    output logic [bsc_pkg::W-1:0]     o_res
);
    import bsc_pkg::*;

    localparam int unsigned CW = $clog2(W);

    logic [W-1:0]  r_a, r_b, r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;

    // shift-add: one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and accumulator words
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + (r_b[0] ? r_a : '0);
            r_a   <= {r_a[W-2:0], 1'b0};
            r_b   <= {1'b0, r_b[W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

`default_nettype wire

// ===== rtl/bsc_div.sv =====
// Bit-serial restoring divider, 32-bit unsigned quotient, one bit per cycle.
`default_nettype none

module bsc_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [bsc_pkg::W-1:0] i_num,
    input  wire logic [bsc_pkg::W-1:0] i_den,
    output logic                      o_done,
    output logic [bsc_pkg::W-1:0]     o_quo
);
    import bsc_pkg::*;

    localparam int unsigned CW = $clog2(W);

    logic [W-1:0]  r_rem, r_quo, r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    w_trial;
    logic          w_fit;

    // shift in the next numerator bit and try a subtract
    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fit ? W'(w_trial - {1'b0, r_den}) : w_trial[W-1:0];
            r_quo <= {r_quo[W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== rtl/barometric_sensor_compensation.sv =====
// Top level: sequencer that runs temperature and pressure compensation on serial units.
//
// Usage: an input word (i_func, i_raw_value) is taken on i_valid & o_ready.
// i_func 0 compensates a temperature and updates the kept fine temperature;
// i_func 1 compensates a pressure using the last fine temperature.
// One result word per input word leaves on o_valid & i_ready.
// Every product goes through a 1-bit-per-cycle multiplier, and the division is
// also 1 bit per cycle. A temperature word takes 3 products, a pressure word
// 10 products and one divide, or 7 products when the divisor is zero.
// One word is in work at a time.
// The result sits in an output register, so a new word is accepted while
// the previous result waits; a stalled receiver holds the next result in
// the finishing step until the output register frees.
// Reset (synchronous, active low) clears the calibration registers, the
// fine temperature and all handshake state. Calibration is written through
// i_cfg_we/i_cfg_idx/i_cfg_data; the user must do so only while idle, which the block does not enforce.
`default_nettype none

module barometric_sensor_compensation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_func,
    input  wire logic [19:0] i_raw_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_kind,
    output logic signed [31:0] o_temperature_centi,
    output logic [31:0]      o_pressure_pa,
    output logic             o_invalid,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);
    import bsc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_MLAUNCH = 6'b000010,
        ST_MWAIT   = 6'b000100,
        ST_DLAUNCH = 6'b001000,
        ST_DWAIT   = 6'b010000,
        ST_DONE    = 6'b100000
    } t_state;

    typedef enum logic [12:0] {
        S_T1  = 13'b0000000000001,
        S_T2  = 13'b0000000000010,
        S_T3  = 13'b0000000000100,
        S_P1  = 13'b0000000001000,
        S_P2  = 13'b0000000010000,
        S_P3  = 13'b0000000100000,
        S_P4  = 13'b0000001000000,
        S_P5  = 13'b0000010000000,
        S_P6  = 13'b0000100000000,
        S_P7  = 13'b0001000000000,
        S_P8  = 13'b0010000000000,
        S_P9  = 13'b0100000000000,
        S_P10 = 13'b1000000000000
    } t_step;

    // calibration registers
    logic [47:0] r_tcal;
    logic [63:0] r_pcal_a, r_pcal_b;
    logic [15:0] r_pcal_c;

    // sequencer and working registers
    t_state       r_state, n_state;
    t_step        r_step, n_step;
    logic [W-1:0] r_ft, n_ft;
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_qq, n_qq;
    logic [W-1:0] r_x1, n_x1;
    logic [W-1:0] r_x2, n_x2;
    logic [W-1:0] r_p, n_p;
    logic         r_bad, n_bad;
    logic [19:0]  r_adc, n_adc;
    logic         r_kind, n_kind;

    // output register
    logic         r_out_valid, n_out_valid;
    logic         r_out_kind, r_out_bad;
    logic [W-1:0] r_out_temp, r_out_press;

    logic [W-1:0] w_op_a, w_op_b, w_mul_res, w_quo, w_tdiff, w_temp;
    logic         w_mul_done, w_div_done, w_take, w_load;

    // calibration halfwords
    logic [15:0] w_t1;
    logic [W-1:0] w_t2, w_t3, w_p2, w_p3, w_p5, w_p6, w_p7, w_p8, w_p9;
    assign w_t1 = r_tcal[15:0];
    assign w_t2 = sx16(r_tcal[31:16]);
    assign w_t3 = sx16(r_tcal[47:32]);
    assign w_p2 = sx16(r_pcal_a[31:16]);
    assign w_p3 = sx16(r_pcal_a[47:32]);
    assign w_p5 = sx16(r_pcal_b[15:0]);
    assign w_p6 = sx16(r_pcal_b[31:16]);
    assign w_p7 = sx16(r_pcal_b[47:32]);
    assign w_p8 = sx16(r_pcal_b[63:48]);
    assign w_p9 = sx16(r_pcal_c);

    assign w_tdiff = {16'b0, r_adc[19:4]} - {16'b0, w_t1};

    // calibration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal   <= '0;
            r_pcal_a <= '0;
            r_pcal_b <= '0;
            r_pcal_c <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEMP:    r_tcal   <= i_cfg_data[47:0];
                CFG_PRESS_A: r_pcal_a <= i_cfg_data;
                CFG_PRESS_B: r_pcal_b <= i_cfg_data;
                CFG_PRESS_C: r_pcal_c <= i_cfg_data[15:0];
                default:     r_pcal_c <= r_pcal_c;
            endcase
        end
    end

    // multiplier operand select per step
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        unique case (r_step)
            S_T1: begin
                w_op_a = {15'b0, r_adc[19:3]} - {15'b0, w_t1, 1'b0};
                w_op_b = w_t2;
            end
            S_T2: begin
                w_op_a = w_tdiff;
                w_op_b = w_tdiff;
            end
            S_T3: begin
                w_op_a = asr(r_qq, 5'd12);
                w_op_b = w_t3;
            end
            S_P1: begin
                w_op_a = asr(r_x1, 5'd2);
                w_op_b = asr(r_x1, 5'd2);
            end
            S_P2: begin
                w_op_a = asr(r_qq, 5'd11);
                w_op_b = w_p6;
            end
            S_P3: begin
                w_op_a = r_x1;
                w_op_b = w_p5;
            end
            S_P4: begin
                w_op_a = w_p3;
                w_op_b = asr(r_qq, 5'd13);
            end
            S_P5: begin
                w_op_a = w_p2;
                w_op_b = r_x1;
            end
            S_P6: begin
                w_op_a = K_HALF_ONE + r_x1;
                w_op_b = {16'b0, r_pcal_a[15:0]};
            end
            S_P7: begin
                w_op_a = (K_ADC_FULL - {12'b0, r_adc}) - asr(r_x2, 5'd12);
                w_op_b = K_PSCALE;
            end
            S_P8: begin
                w_op_a = {3'b0, r_p[W-1:3]};
                w_op_b = {3'b0, r_p[W-1:3]};
            end
            S_P9: begin
                w_op_a = w_p9;
                w_op_b = r_acc;
            end
            S_P10: begin
                w_op_a = {2'b0, r_p[W-1:2]};
                w_op_b = w_p8;
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    bsc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_MLAUNCH),
        .i_a     (w_op_a),
        .i_b     (w_op_b),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DLAUNCH),
        .i_num   (r_p[W-1] ? r_p : {r_p[W-2:0], 1'b0}),
        .i_den   (r_x1),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_ready = (r_state == ST_IDLE);
    assign w_take  = i_valid && o_ready;
    assign w_load  = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    // sequencer and write-back
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_ft    = r_ft;
        n_acc   = r_acc;
        n_qq    = r_qq;
        n_x1    = r_x1;
        n_x2    = r_x2;
        n_p     = r_p;
        n_bad   = r_bad;
        n_adc   = r_adc;
        n_kind  = r_kind;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_adc   = i_raw_value;
                    n_kind  = i_func;
                    n_bad   = 1'b0;
                    n_x1    = asr(r_ft, 5'd1) - K_X1_OFFSET;
                    n_step  = i_func ? S_P1 : S_T1;
                    n_state = ST_MLAUNCH;
                end
            end
            ST_MLAUNCH: n_state = ST_MWAIT;
            ST_MWAIT: begin
                if (w_mul_done) begin
                    n_state = ST_MLAUNCH;
                    unique case (r_step)
                        S_T1: begin
                            n_acc  = asr(w_mul_res, 5'd11);
                            n_step = S_T2;
                        end
                        S_T2: begin
                            n_qq   = w_mul_res;
                            n_step = S_T3;
                        end
                        S_T3: begin
                            n_ft    = r_acc + asr(w_mul_res, 5'd14);
                            n_state = ST_DONE;
                        end
                        S_P1: begin
                            n_qq   = w_mul_res;
                            n_step = S_P2;
                        end
                        S_P2: begin
                            n_x2   = w_mul_res;
                            n_step = S_P3;
                        end
                        S_P3: begin
                            n_x2 = asr(r_x2 + {w_mul_res[W-2:0], 1'b0}, 5'd2)
                                 + {r_pcal_a[63:48], 16'b0};
                            n_step = S_P4;
                        end
                        S_P4: begin
                            n_acc  = w_mul_res;
                            n_step = S_P5;
                        end
                        S_P5: begin
                            n_x1 = asr(asr(r_acc, 5'd3) + asr(w_mul_res, 5'd1), 5'd18);
                            n_step = S_P6;
                        end
                        S_P6: begin
                            n_x1   = asr(w_mul_res, 5'd15);
                            n_step = S_P7;
                        end
                        S_P7: begin
                            n_p = w_mul_res;
                            // zero divisor: flag and finish
                            if (r_x1 == '0) begin
                                n_bad   = 1'b1;
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_DLAUNCH;
                            end
                        end
                        S_P8: begin
                            n_acc  = {13'b0, w_mul_res[W-1:13]};
                            n_step = S_P9;
                        end
                        S_P9: begin
                            n_acc  = asr(w_mul_res, 5'd12);
                            n_step = S_P10;
                        end
                        S_P10: begin
                            n_p = r_p + asr(r_acc + asr(w_mul_res, 5'd13) + w_p7, 5'd4);
                            n_state = ST_DONE;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_DLAUNCH: n_state = ST_DWAIT;
            ST_DWAIT: begin
                if (w_div_done) begin
                    n_p     = r_p[W-1] ? {w_quo[W-2:0], 1'b0} : w_quo;
                    n_step  = S_P8;
                    n_state = ST_MLAUNCH;
                end
            end
            ST_DONE: begin
                if (w_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // temperature = (ft * 5 + 128) >> 8
    assign w_temp = asr(r_ft + {r_ft[W-3:0], 2'b0} + K_ROUND, 5'd8);

    // output handshake
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load)       n_out_valid = 1'b1;
        else if (i_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= S_T1;
            r_ft        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_ft        <= n_ft;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_qq   <= n_qq;
        r_x1   <= n_x1;
        r_x2   <= n_x2;
        r_p    <= n_p;
        r_bad  <= n_bad;
        r_adc  <= n_adc;
        r_kind <= n_kind;
        if (w_load) begin
            r_out_kind  <= r_kind;
            r_out_bad   <= r_kind & r_bad;
            r_out_temp  <= r_kind ? '0 : w_temp;
            r_out_press <= (r_kind && !r_bad) ? r_p : '0;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_kind              = r_out_kind;
    assign o_temperature_centi = $signed(r_out_temp);
    assign o_pressure_pa       = r_out_press;
    assign o_invalid           = r_out_bad;

    // checks
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("sequencer state not one-hot");

    a_idle_units_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!w_mul_done && !w_div_done))
        else $error("serial unit finished while idle");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_press == '0))
        else $error("invalid result with nonzero pressure");

    a_temp_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_kind) |-> (r_out_press == '0 && !r_out_bad))
        else $error("temperature result carries pressure fields");

    a_load_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == ST_IDLE && r_out_valid))
        else $error("result load did not return to idle");

endmodule

`default_nettype wire
